// ----- src/cba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// Shared constants and types of the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

   localparam int TOTAL_BLOCK_COUNT = 2048;
   localparam int BYTES_PER_BLOCK   = 512;
   localparam int CATALOG_DEPTH     = 64;

   localparam int BLOCK_BITS  = $clog2(TOTAL_BLOCK_COUNT);    // 11
   localparam int WORD_BITS   = 32;
   localparam int OFFS_BITS   = $clog2(WORD_BITS);            // 5
   localparam int BWORD_BITS  = BLOCK_BITS - OFFS_BITS;       // 6
   localparam int SLOT_BITS   = $clog2(CATALOG_DEPTH);        // 6
   localparam int SHIFT_BITS  = $clog2(BYTES_PER_BLOCK);      // 9

   localparam int CMD_W    = 3;
   localparam int KEY_W    = 32;
   localparam int SIZE_W   = 21;
   localparam int STAT_W   = 3;
   localparam int COUNT_W  = 12;
   localparam int NEED_W   = 13;
   localparam int DSTART_W = 11;
   localparam int MAXF_W   = 7;

   localparam logic [CMD_W-1:0] CMD_FORMAT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_UNDELETE = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOSPACE   = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd3;
   localparam logic [STAT_W-1:0] ST_NORESTORE = 3'd4;

   localparam logic [0:0] REG_DATA_START = 1'b0;

   typedef struct packed {
      logic [SIZE_W-1:0]     size;
      logic [COUNT_W-1:0]    blocks;
      logic [BLOCK_BITS-1:0] start;
      logic [KEY_W-1:0]      key;
   } cat_entry_type;

   localparam int ENTRY_W = $bits(cat_entry_type);

endpackage

// ----- src/cba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cba_ram #(
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 6
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);
   logic [WIDTH-1:0] mem [2**ADDR_BITS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- src/contiguous_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// First-fit contiguous block allocator with a keyed file catalog. Bitmap of
// used blocks in a 64 x 32 RAM, catalog fields in a 64-entry RAM, entry flags
// in flops.
// Format rewrites every bitmap word; read searches catalog entries in turn;
// write searches for a free slot, then scans bitmap words and marks the
// words of the run; delete/undelete rewrite each word of the run (undelete
// first checks the words of the run). One command at a time; the bitmap word
// scan (8 blocks per cycle) sets the write time.
// Reset: synchronous; a pass rewrites every bitmap word from data_start,
// no command is taken until it ends (register writes are taken).
// ----------------------------------------------------------------------------
module contiguous_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,    // command[2:0], file_key[34:3], size_bytes[55:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // status[2:0], start_block[13:3], block_count[25:14],
                                     // file_size[46:26], slot[52:47], zero[55:53]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cba_pkg::*;

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SLOT   = 4'd2;
   localparam logic [3:0] S_FIT_RD = 4'd3;
   localparam logic [3:0] S_FIT    = 4'd4;
   localparam logic [3:0] S_LK_RD  = 4'd5;
   localparam logic [3:0] S_LK     = 4'd6;
   localparam logic [3:0] S_WK_RD  = 4'd7;
   localparam logic [3:0] S_WK     = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   localparam logic [BWORD_BITS-1:0] LAST_WORD = {BWORD_BITS{1'b1}};

   // configuration
   logic [DSTART_W-1:0] ds_ff, ds_in;
   logic [MAXF_W-1:0]   mf_ff, mf_in;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      ds_in = ds_ff;
      mf_in = mf_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_DATA_START) begin
            ds_in = csr_pwdata[DSTART_W-1:0];
         end else begin
            mf_in = csr_pwdata[MAXF_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_DATA_START) ? {21'd0, ds_ff} : {25'd0, mf_ff};

   // control and working registers
   logic [3:0]              state_ff, state_in;
   logic                    fmt_cmd_ff, fmt_cmd_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic [NEED_W-1:0]       need_ff, need_in;
   logic [MAXF_W-1:0]       idx_ff, idx_in;
   logic [BWORD_BITS-1:0]   wp_ff, wp_in;
   logic [1:0]              chunk_ff, chunk_in;
   logic [COUNT_W-1:0]      run_ff, run_in;
   logic [BLOCK_BITS-1:0]   fstart_ff, fstart_in;
   logic [BWORD_BITS-1:0]   wk_word_ff, wk_word_in;
   logic                    wk_check_ff, wk_check_in;
   logic                    wk_val_ff, wk_val_in;
   logic [CATALOG_DEPTH-1:0] used_ff, used_in;
   logic [CATALOG_DEPTH-1:0] del_ff, del_in;
   logic [STAT_W-1:0]       res_status_ff, res_status_in;
   logic [BLOCK_BITS-1:0]   res_start_ff, res_start_in;
   logic [COUNT_W-1:0]      res_blocks_ff, res_blocks_in;
   logic [SIZE_W-1:0]       res_size_ff, res_size_in;
   logic [SLOT_BITS-1:0]    res_slot_ff, res_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [55:0]             rsp_data_ff, rsp_data_in;

   // memories
   logic                  bm_we;
   logic [BWORD_BITS-1:0] bm_waddr, bm_raddr;
   logic [WORD_BITS-1:0]  bm_wdata, bm_rdata;
   logic                  cat_we;
   logic [SLOT_BITS-1:0]  cat_raddr;
   cat_entry_type         cat_wdata, cat_rdata;

   cba_ram #(.WIDTH(WORD_BITS), .ADDR_BITS(BWORD_BITS)) u_bitmap (
      .clock(clock), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
      .raddr(bm_raddr), .rdata(bm_rdata)
   );

   cba_ram #(.WIDTH(ENTRY_W), .ADDR_BITS(SLOT_BITS)) u_catalog (
      .clock(clock), .we(cat_we), .waddr(idx_ff[SLOT_BITS-1:0]), .wdata(cat_wdata),
      .raddr(cat_raddr), .rdata(cat_rdata)
   );

   // derived values
   logic [MAXF_W-1:0]     n_files;
   logic [NEED_W-1:0]     need_calc;
   logic [NEED_W-1:0]     wk_end, wk_endm1;
   logic [BWORD_BITS-1:0] wk_last;
   logic [WORD_BITS-1:0]  wk_mask, fmt_mask;
   logic                  fit_hit;
   logic [COUNT_W-1:0]    fit_run;
   logic [BLOCK_BITS-1:0] fit_start, fit_hstart;
   logic                  req_acc;
   logic [CMD_W-1:0]      req_cmd;
   logic [SIZE_W-1:0]     req_size;
   logic                  lk_match;

   assign n_files   = (mf_ff > MAXF_W'(CATALOG_DEPTH)) ? MAXF_W'(CATALOG_DEPTH) : mf_ff;
   assign req_cmd   = req_tdata[2:0];
   assign req_size  = req_tdata[55:35];
   assign need_calc = NEED_W'((({1'b0, req_size}) + 22'(BYTES_PER_BLOCK - 1)) >> SHIFT_BITS);
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc   = req_tvalid & req_tready;

   assign wk_end  = {2'b00, res_start_ff} + {1'b0, res_blocks_ff};
   assign wk_endm1 = wk_end - NEED_W'(1);
   assign wk_last = (wk_endm1[NEED_W-1:BLOCK_BITS] != '0) ? LAST_WORD
                                                          : wk_endm1[BLOCK_BITS-1:OFFS_BITS];

   always_comb begin
      logic [BLOCK_BITS-1:0] bidx;
      for (int p = 0; p < WORD_BITS; p++) begin
         bidx = {wk_word_ff, OFFS_BITS'(p)};
         wk_mask[p] = (bidx >= res_start_ff) && ({2'b00, bidx} < wk_end);
         fmt_mask[p] = ({idx_ff[BWORD_BITS-1:0], OFFS_BITS'(p)} < ds_ff);
      end
   end

   // one byte of the bitmap word per cycle through the first-fit run tracker
   always_comb begin
      logic [7:0]            bits8;
      logic [BLOCK_BITS-1:0] bidx;
      logic                  busy;
      bits8      = bm_rdata[{chunk_ff, 3'b000} +: 8];
      fit_hit    = 1'b0;
      fit_run    = run_ff;
      fit_start  = fstart_ff;
      fit_hstart = fstart_ff;
      for (int k = 0; k < 8; k++) begin
         bidx = {wp_ff, chunk_ff, 3'(k)};
         busy = bits8[k] || (bidx < ds_ff);
         if (!fit_hit) begin
            if (!busy) begin
               if (fit_run == '0) begin
                  fit_start = bidx;
               end
               fit_run = fit_run + COUNT_W'(1);
               if (fit_run == need_ff[COUNT_W-1:0]) begin
                  fit_hit    = 1'b1;
                  fit_hstart = fit_start;
               end
            end else begin
               fit_run = '0;
            end
         end
      end
   end

   assign lk_match = used_ff[idx_ff[SLOT_BITS-1:0]]
                  && (del_ff[idx_ff[SLOT_BITS-1:0]] == (cmd_ff == CMD_UNDELETE))
                  && (cat_rdata.key == key_ff);

   always_comb begin
      state_in      = state_ff;
      fmt_cmd_in    = fmt_cmd_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      size_in       = size_ff;
      need_in       = need_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      chunk_in      = chunk_ff;
      run_in        = run_ff;
      fstart_in     = fstart_ff;
      wk_word_in    = wk_word_ff;
      wk_check_in   = wk_check_ff;
      wk_val_in     = wk_val_ff;
      used_in       = used_ff;
      del_in        = del_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_blocks_in = res_blocks_ff;
      res_size_in   = res_size_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      bm_we         = 1'b0;
      bm_waddr      = wk_word_ff;
      bm_wdata      = wk_val_ff ? (bm_rdata | wk_mask) : (bm_rdata & ~wk_mask);
      bm_raddr      = wk_word_ff;
      cat_we        = 1'b0;
      cat_raddr     = idx_ff[SLOT_BITS-1:0];
      cat_wdata     = '{size: size_ff, blocks: need_ff[COUNT_W-1:0],
                        start: fit_hstart, key: key_ff};

      unique case (state_ff)
         S_INIT: begin
            bm_we    = 1'b1;
            bm_waddr = idx_ff[BWORD_BITS-1:0];
            bm_wdata = fmt_mask;
            idx_in   = idx_ff + MAXF_W'(1);
            if (idx_ff[BWORD_BITS-1:0] == LAST_WORD) begin
               if (fmt_cmd_ff) begin
                  res_status_in = ST_OK;
                  res_start_in  = '0;
                  res_blocks_in = '0;
                  res_size_in   = '0;
                  res_slot_in   = '0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               cmd_in        = req_cmd;
               key_in        = req_tdata[34:3];
               size_in       = req_size;
               need_in       = (need_calc == '0) ? NEED_W'(1) : need_calc;
               idx_in        = '0;
               res_start_in  = '0;
               res_blocks_in = '0;
               res_size_in   = '0;
               res_slot_in   = '0;
               unique case (req_cmd) inside
                  CMD_FORMAT: begin
                     fmt_cmd_in = 1'b1;
                     used_in    = '0;
                     del_in     = '0;
                     state_in   = S_INIT;
                  end
                  CMD_WRITE: state_in = S_SLOT;
                  CMD_READ, CMD_DELETE, CMD_UNDELETE: state_in = S_LK_RD;
                  default: begin
                     res_status_in = ST_NOTFOUND;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_SLOT: begin
            if (idx_ff == n_files) begin
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else if (!used_ff[idx_ff[SLOT_BITS-1:0]]) begin
               if (need_ff > NEED_W'(TOTAL_BLOCK_COUNT)) begin
                  res_status_in = ST_NOSPACE;
                  state_in      = S_DONE;
               end else begin
                  wp_in    = ds_ff[BLOCK_BITS-1:OFFS_BITS];
                  run_in   = '0;
                  state_in = S_FIT_RD;
               end
            end else begin
               idx_in = idx_ff + MAXF_W'(1);
            end
         end
         S_FIT_RD: begin
            bm_raddr = wp_ff;
            chunk_in = '0;
            state_in = S_FIT;
         end
         S_FIT: begin
            bm_raddr  = wp_ff;
            run_in    = fit_run;
            fstart_in = fit_start;
            chunk_in  = chunk_ff + 2'd1;
            if (fit_hit) begin
               cat_we             = 1'b1;
               used_in[idx_ff[SLOT_BITS-1:0]] = 1'b1;
               del_in[idx_ff[SLOT_BITS-1:0]]  = 1'b0;
               res_status_in      = ST_OK;
               res_start_in       = fit_hstart;
               res_blocks_in      = need_ff[COUNT_W-1:0];
               res_size_in        = size_ff;
               res_slot_in        = idx_ff[SLOT_BITS-1:0];
               wk_word_in         = fit_hstart[BLOCK_BITS-1:OFFS_BITS];
               wk_check_in        = 1'b0;
               wk_val_in          = 1'b1;
               state_in           = S_WK_RD;
            end else if (chunk_ff == 2'd3) begin
               if (wp_ff == LAST_WORD) begin
                  res_status_in = ST_NOSPACE;
                  state_in      = S_DONE;
               end else begin
                  wp_in    = wp_ff + BWORD_BITS'(1);
                  state_in = S_FIT_RD;
               end
            end
         end
         S_LK_RD: begin
            if (idx_ff == n_files) begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_DONE;
            end else begin
               state_in = S_LK;
            end
         end
         S_LK: begin
            if (lk_match) begin
               res_status_in = ST_OK;
               res_start_in  = cat_rdata.start;
               res_blocks_in = cat_rdata.blocks;
               res_size_in   = cat_rdata.size;
               res_slot_in   = idx_ff[SLOT_BITS-1:0];
               wk_word_in    = cat_rdata.start[BLOCK_BITS-1:OFFS_BITS];
               case (cmd_ff)
                  CMD_DELETE: begin
                     del_in[idx_ff[SLOT_BITS-1:0]] = 1'b1;
                     wk_check_in = 1'b0;
                     wk_val_in   = 1'b0;
                     state_in    = S_WK_RD;
                  end
                  CMD_UNDELETE: begin
                     wk_check_in = 1'b1;
                     wk_val_in   = 1'b1;
                     state_in    = S_WK_RD;
                  end
                  default: state_in = S_DONE;
               endcase
            end else begin
               idx_in   = idx_ff + MAXF_W'(1);
               state_in = S_LK_RD;
            end
         end
         S_WK_RD: begin
            state_in = S_WK;
         end
         S_WK: begin
            if (wk_check_ff) begin
               // restore check: any used block in the run means release
               if ((bm_rdata & wk_mask) != '0) begin
                  used_in[idx_ff[SLOT_BITS-1:0]] = 1'b0;
                  res_status_in = ST_NORESTORE;
                  state_in      = S_DONE;
               end else if (wk_word_ff == wk_last) begin
                  del_in[idx_ff[SLOT_BITS-1:0]] = 1'b0;
                  wk_check_in = 1'b0;
                  wk_word_in  = res_start_ff[BLOCK_BITS-1:OFFS_BITS];
                  state_in    = S_WK_RD;
               end else begin
                  wk_word_in = wk_word_ff + BWORD_BITS'(1);
                  state_in   = S_WK_RD;
               end
            end else begin
               bm_we = 1'b1;
               if (wk_word_ff == wk_last) begin
                  state_in = S_DONE;
               end else begin
                  wk_word_in = wk_word_ff + BWORD_BITS'(1);
                  state_in   = S_WK_RD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_slot_ff, res_size_ff, res_blocks_ff,
                               res_start_ff, res_status_ff};
               fmt_cmd_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         fmt_cmd_ff   <= 1'b0;
         idx_ff       <= '0;
         used_ff      <= '0;
         del_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ds_ff        <= DSTART_W'(6);
         mf_ff        <= MAXF_W'(46);
      end else begin
         state_ff     <= state_in;
         fmt_cmd_ff   <= fmt_cmd_in;
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         del_ff       <= del_in;
         rsp_valid_ff <= rsp_valid_in;
         ds_ff        <= ds_in;
         mf_ff        <= mf_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      size_ff       <= size_in;
      need_ff       <= need_in;
      wp_ff         <= wp_in;
      chunk_ff      <= chunk_in;
      run_ff        <= run_in;
      fstart_ff     <= fstart_in;
      wk_word_ff    <= wk_word_in;
      wk_check_ff   <= wk_check_in;
      wk_val_ff     <= wk_val_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_blocks_ff <= res_blocks_in;
      res_size_ff   <= res_size_in;
      res_slot_ff   <= res_slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
